@@ hdl/frc8_pkg.sv @@
`default_nettype none

package frc8_pkg;

	// frame geometry: code, length, up to MAX_FRAME-2 payload bytes
	localparam int MAX_FRAME = 21;
	localparam int ADDR_W = $clog2(MAX_FRAME);
	localparam int LEN_W = 5;
	localparam int IDX_W = 5;
	localparam int KIND_W = 3;
	localparam int BYTE_W = 8;

	localparam logic [BYTE_W-1:0] CRC_POLY = 8'hD5;
	localparam logic [BYTE_W-1:0] PRE_FIRST = 8'hAA;
	localparam logic [BYTE_W-1:0] PRE_SECOND = 8'h55;
	localparam logic [BYTE_W-1:0] MAX_LEN = 8'(MAX_FRAME - 2);

	// event kinds on the result channel
	localparam logic [KIND_W-1:0] EV_BYTE = 3'd0;
	localparam logic [KIND_W-1:0] EV_BADPRE = 3'd1;
	localparam logic [KIND_W-1:0] EV_BADLEN = 3'd2;
	localparam logic [KIND_W-1:0] EV_CRC = 3'd3;
	localparam logic [KIND_W-1:0] EV_ECHO = 3'd4;

	// controller to datapath
	typedef struct packed {
		logic store_code;
		logic store_len;
		logic store_data;
		logic post_event;
		logic [KIND_W-1:0] kind;
		logic emit_clear;
		logic emit_read;
		logic emit_post;
	} frc8_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic is_pre1;
		logic is_pre2;
		logic len_bad;
		logic len_zero;
		logic data_done;
		logic crc_match;
		logic code_odd;
		logic emit_last;
		logic out_free;
	} frc8_stat_t;

	// crc-8, msb first, one byte
	function automatic logic [BYTE_W-1:0] crc8_update(input logic [BYTE_W-1:0] crc,
		input logic [BYTE_W-1:0] b);
		logic [BYTE_W-1:0] v;
		v = crc ^ b;
		for (int k = 0; k < BYTE_W; k++) begin
			if (v[BYTE_W-1]) begin
				v = (v << 1) ^ CRC_POLY;
			end else begin
				v = v << 1;
			end
		end
		return v;
	endfunction

endpackage

`default_nettype wire

@@ hdl/frc8_if.sv @@
`default_nettype none

// byte request channel
interface frc8_in_if;
	import frc8_pkg::*;
	logic valid;
	logic ready;
	logic [BYTE_W-1:0] rx_byte;
	modport source (output valid, output rx_byte, input ready);
	modport sink (input valid, input rx_byte, output ready);
endinterface

// result request channel
interface frc8_out_if;
	import frc8_pkg::*;
	logic valid;
	logic ready;
	logic [KIND_W-1:0] event_kind;
	logic [BYTE_W-1:0] frame_byte;
	logic [IDX_W-1:0] byte_index;
	logic last;
	modport source (output valid, output event_kind, output frame_byte,
		output byte_index, output last, input ready);
	modport sink (input valid, input event_kind, input frame_byte,
		input byte_index, input last, output ready);
endinterface

`default_nettype wire

@@ hdl/preamble_frame_receiver_crc8.sv @@
// framed byte receiver with crc-8 check
// rx: one received serial byte per request (valid/ready, rx_byte)
// ev: result requests (event_kind, frame_byte, byte_index, last)
// a frame is 0xaa 0x55, code, length, payload, crc-8 (poly 0xd5, init 0)
// throughput: one byte per cycle while parsing and not held off; a byte that cannot cause
//   a result is taken even while an earlier result waits on ev
// an error result is loaded into the ev output register by the clock edge
//   that takes the byte that caused it
// on a crc match the stored frame is played out byte by byte, each byte read
//   from the registered frame store and then loaded into the output register
//   once it is free; rx is held off for that burst of up to 21 results
// reset: hunting for the first preamble byte, output register empty,
//   frame store contents undefined
// a stalled ev holds its request and rx is held off whenever the next
//   byte could need the output register
`default_nettype none

module preamble_frame_receiver_crc8 (
	input wire logic clk,
	input wire logic arst_n,
	frc8_in_if.sink rx,
	frc8_out_if.source ev
);
	import frc8_pkg::*;

	frc8_cmd_t cmd;
	frc8_stat_t stat;

	// sequencing of preamble, header, payload, crc and frame playback
	frc8_ctrl u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(rx.valid),
		.in_ready(rx.ready),
		.stat(stat),
		.cmd(cmd)
	);

	// frame store, crc, counters and output register
	frc8_dp u_dp (
		.clk(clk),
		.arst_n(arst_n),
		.rx_byte(rx.rx_byte),
		.cmd(cmd),
		.stat(stat),
		.out_valid(ev.valid),
		.out_ready(ev.ready),
		.event_kind(ev.event_kind),
		.frame_byte(ev.frame_byte),
		.byte_index(ev.byte_index),
		.last(ev.last)
	);

endmodule

`default_nettype wire

@@ hdl/frc8_dp.sv @@
`default_nettype none

module frc8_dp (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic [frc8_pkg::BYTE_W-1:0] rx_byte,
	input wire frc8_pkg::frc8_cmd_t cmd,
	output frc8_pkg::frc8_stat_t stat,
	output logic out_valid,
	input wire logic out_ready,
	output logic [frc8_pkg::KIND_W-1:0] event_kind,
	output logic [frc8_pkg::BYTE_W-1:0] frame_byte,
	output logic [frc8_pkg::IDX_W-1:0] byte_index,
	output logic last
);
	import frc8_pkg::*;

	logic [BYTE_W-1:0] mem [MAX_FRAME];
	logic [BYTE_W-1:0] rd_q;
	logic [BYTE_W-1:0] crc_q;
	logic [LEN_W-1:0] len_q;
	logic [LEN_W-1:0] cnt_q;
	logic code_odd_q;
	logic [ADDR_W-1:0] idx_q;
	logic ovalid_q;
	logic wr_en;
	logic [ADDR_W-1:0] wr_addr;
	logic [LEN_W:0] cnt_inc;
	logic [ADDR_W-1:0] data_addr;

	assign cnt_inc = {1'b0, cnt_q} + (LEN_W+1)'(1);
	assign data_addr = ADDR_W'(cnt_q) + ADDR_W'(2);

	always_comb begin
		wr_en = cmd.store_code | cmd.store_len | cmd.store_data;
		if (cmd.store_code) begin
			wr_addr = ADDR_W'(0);
		end else if (cmd.store_len) begin
			wr_addr = ADDR_W'(1);
		end else begin
			wr_addr = data_addr;
		end
	end

	always_comb begin
		stat.is_pre1 = (rx_byte == PRE_FIRST);
		stat.is_pre2 = (rx_byte == PRE_SECOND);
		stat.len_bad = (rx_byte > MAX_LEN);
		stat.len_zero = (rx_byte == '0);
		stat.data_done = (cnt_inc >= {1'b0, len_q});
		stat.crc_match = (crc_q == rx_byte);
		stat.code_odd = code_odd_q;
		stat.emit_last = ({1'b0, idx_q} == ({1'b0, len_q} + (LEN_W+1)'(1)));
		stat.out_free = !ovalid_q || out_ready;
	end

	// frame store, registered read
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= rx_byte;
		end
		if (cmd.emit_read) begin
			rd_q <= mem[idx_q];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			crc_q <= '0;
			len_q <= '0;
			cnt_q <= '0;
			code_odd_q <= 1'b0;
			idx_q <= '0;
		end else begin
			if (cmd.store_code) begin
				crc_q <= crc8_update('0, rx_byte);
				code_odd_q <= rx_byte[0];
			end
			if (cmd.store_len && !stat.len_bad) begin
				crc_q <= crc8_update(crc_q, rx_byte);
				len_q <= rx_byte[LEN_W-1:0];
				cnt_q <= '0;
			end
			if (cmd.store_data) begin
				crc_q <= crc8_update(crc_q, rx_byte);
				cnt_q <= cnt_inc[LEN_W-1:0];
			end
			if (cmd.emit_clear) begin
				idx_q <= '0;
			end else if (cmd.emit_post) begin
				idx_q <= idx_q + ADDR_W'(1);
			end
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ovalid_q <= 1'b0;
		end else if (cmd.post_event || cmd.emit_post) begin
			ovalid_q <= 1'b1;
		end else if (out_ready) begin
			ovalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.post_event) begin
			event_kind <= cmd.kind;
			frame_byte <= '0;
			byte_index <= '0;
			last <= 1'b1;
		end else if (cmd.emit_post) begin
			event_kind <= EV_BYTE;
			frame_byte <= rd_q;
			byte_index <= IDX_W'(idx_q);
			last <= stat.emit_last;
		end
	end

	assign out_valid = ovalid_q;

endmodule

`default_nettype wire

@@ hdl/frc8_ctrl.sv @@
`default_nettype none

module frc8_ctrl (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_valid,
	output logic in_ready,
	input wire frc8_pkg::frc8_stat_t stat,
	output frc8_pkg::frc8_cmd_t cmd
);
	import frc8_pkg::*;

	localparam logic [2:0] PH_PRE1 = 3'd0;
	localparam logic [2:0] PH_PRE2 = 3'd1;
	localparam logic [2:0] PH_CODE = 3'd2;
	localparam logic [2:0] PH_LEN = 3'd3;
	localparam logic [2:0] PH_DATA = 3'd4;
	localparam logic [2:0] PH_CRC = 3'd5;
	localparam logic [2:0] PH_RD = 3'd6;
	localparam logic [2:0] PH_LD = 3'd7;

	logic [2:0] state_q;
	logic [2:0] state_d;
	logic parsing;
	logic silent;
	logic acc;

	always_comb begin
		parsing = (state_q <= PH_CRC);
		// phases whose byte never makes a result
		silent = (state_q == PH_PRE1) || (state_q == PH_CODE) || (state_q == PH_DATA);
		in_ready = parsing && (silent || stat.out_free);
		acc = in_valid && in_ready;
	end

	always_comb begin
		cmd = '0;
		state_d = state_q;
		case (state_q)
			PH_PRE1: begin
				if (acc && stat.is_pre1) begin
					state_d = PH_PRE2;
				end
			end
			PH_PRE2: begin
				if (acc) begin
					if (stat.is_pre2) begin
						state_d = PH_CODE;
					end else begin
						cmd.post_event = 1'b1;
						cmd.kind = EV_BADPRE;
						state_d = PH_PRE1;
					end
				end
			end
			PH_CODE: begin
				if (acc) begin
					cmd.store_code = 1'b1;
					state_d = PH_LEN;
				end
			end
			PH_LEN: begin
				if (acc) begin
					cmd.store_len = 1'b1;
					if (stat.len_bad) begin
						cmd.post_event = 1'b1;
						cmd.kind = EV_BADLEN;
						state_d = PH_PRE1;
					end else if (stat.len_zero) begin
						state_d = PH_CRC;
					end else begin
						state_d = PH_DATA;
					end
				end
			end
			PH_DATA: begin
				if (acc) begin
					cmd.store_data = 1'b1;
					if (stat.data_done) begin
						state_d = PH_CRC;
					end
				end
			end
			PH_CRC: begin
				if (acc) begin
					if (stat.crc_match) begin
						cmd.emit_clear = 1'b1;
						state_d = PH_RD;
					end else begin
						cmd.post_event = 1'b1;
						cmd.kind = stat.code_odd ? EV_ECHO : EV_CRC;
						state_d = PH_PRE1;
					end
				end
			end
			PH_RD: begin
				cmd.emit_read = 1'b1;
				state_d = PH_LD;
			end
			PH_LD: begin
				if (stat.out_free) begin
					cmd.emit_post = 1'b1;
					state_d = stat.emit_last ? PH_PRE1 : PH_RD;
				end
			end
			default: begin
				state_d = PH_PRE1;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= PH_PRE1;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

`default_nettype wire

@@ tb/sv/frc8_tb_pkg.sv @@
package frc8_tb_pkg;
	import frc8_pkg::*;

	typedef enum logic [2:0] {
		HUNT_SYNC1,
		HUNT_SYNC2,
		GET_CODE,
		GET_LEN,
		GET_PAYLOAD,
		GET_CRC
	} rx_phase_e;

	typedef struct packed {
		logic [KIND_W-1:0] kind;
		logic [BYTE_W-1:0] data;
		logic [IDX_W-1:0] idx;
		logic last;
	} frc8_result_t;

	// bit-serial crc-8, message bit fed against the register msb
	function automatic logic [BYTE_W-1:0] crc8_d5_step(input logic [BYTE_W-1:0] acc,
		input logic [BYTE_W-1:0] b);
		logic [BYTE_W-1:0] r;
		logic fb;
		r = acc;
		for (int i = BYTE_W - 1; i >= 0; i--) begin
			fb = r[BYTE_W-1] ^ b[i];
			r = {r[BYTE_W-2:0], 1'b0} ^ (fb ? CRC_POLY : '0);
		end
		return r;
	endfunction

	class frame_scoreboard;
		rx_phase_e phase;
		logic [LEN_W-1:0] pay_len;
		logic [LEN_W-1:0] pay_cnt;
		logic [BYTE_W-1:0] crc_acc;
		logic [BYTE_W-1:0] frame_mem [MAX_FRAME];
		frc8_result_t expected_q [$];
		int mismatches;
		int checked;

		function new();
			phase = HUNT_SYNC1;
			pay_len = '0;
			pay_cnt = '0;
			crc_acc = '0;
			mismatches = 0;
			checked = 0;
		endfunction

		function void expect_result(input logic [KIND_W-1:0] kind,
			input logic [BYTE_W-1:0] data, input int idx, input logic last);
			frc8_result_t r;
			r.kind = kind;
			r.data = data;
			r.idx = IDX_W'(idx);
			r.last = last;
			expected_q.push_back(r);
		endfunction

		// one accepted serial byte
		function void note_byte(input logic [BYTE_W-1:0] b);
			int total;
			case (phase)
				HUNT_SYNC2: begin
					if (b == PRE_SECOND) begin
						phase = GET_CODE;
					end else begin
						expect_result(EV_BADPRE, '0, 0, 1'b1);
						phase = HUNT_SYNC1;
					end
				end
				GET_CODE: begin
					frame_mem[0] = b;
					crc_acc = crc8_d5_step('0, b);
					phase = GET_LEN;
				end
				GET_LEN: begin
					frame_mem[1] = b;
					if (b > MAX_LEN) begin
						expect_result(EV_BADLEN, '0, 0, 1'b1);
						phase = HUNT_SYNC1;
					end else begin
						crc_acc = crc8_d5_step(crc_acc, b);
						pay_len = b[LEN_W-1:0];
						pay_cnt = '0;
						phase = (b == 0) ? GET_CRC : GET_PAYLOAD;
					end
				end
				GET_PAYLOAD: begin
					frame_mem[2 + int'(pay_cnt)] = b;
					crc_acc = crc8_d5_step(crc_acc, b);
					pay_cnt++;
					if (pay_cnt >= pay_len) begin
						phase = GET_CRC;
					end
				end
				GET_CRC: begin
					if (crc_acc == b) begin
						total = 2 + int'(pay_len);
						for (int i = 0; i < total; i++) begin
							expect_result(EV_BYTE, frame_mem[i], i, i == total - 1);
						end
					end else if (frame_mem[0][0]) begin
						expect_result(EV_ECHO, '0, 0, 1'b1);
					end else begin
						expect_result(EV_CRC, '0, 0, 1'b1);
					end
					phase = HUNT_SYNC1;
				end
				default: begin
					phase = (b == PRE_FIRST) ? HUNT_SYNC2 : HUNT_SYNC1;
				end
			endcase
		endfunction

		function void report(input string what, input frc8_result_t want,
			input frc8_result_t got);
			mismatches++;
			if (mismatches <= 10) begin
				$write("%0t: %s: want kind %0d byte %02h idx %0d last %0d, ",
					$time, what, want.kind, want.data, want.idx, want.last);
				$display("got kind %0d byte %02h idx %0d last %0d",
					got.kind, got.data, got.idx, got.last);
			end
		endfunction

		// one accepted result request
		function void check_result(input frc8_result_t got);
			frc8_result_t want;
			checked++;
			if (expected_q.size() == 0) begin
				report("unexpected result", '0, got);
				return;
			end
			want = expected_q.pop_front();
			if (got.kind !== want.kind || got.data !== want.data ||
				got.idx !== want.idx || got.last !== want.last) begin
				report("result mismatch", want, got);
			end
		endfunction

		function int pending();
			return expected_q.size();
		endfunction
	endclass

endpackage

@@ tb/sv/testbench.sv @@
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	import frc8_pkg::*;
	import frc8_tb_pkg::*;

	logic clk;
	logic arst_n;

	frc8_in_if rx_ch();
	frc8_out_if ev_ch();

	preamble_frame_receiver_crc8 u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.rx(rx_ch),
		.ev(ev_ch)
	);

	frame_scoreboard sb = new();

	// idle percentages for each side, changed between stimulus phases
	int tx_idle_pct = 38;
	int rx_idle_pct = 50;
	// asks the result side for one long hold-off
	bit long_hold_due = 1'b0;
	int bytes_sent = 0;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// hard stop in case the handshake hangs
	initial begin
		#10_000_000;
		$display("end of test: mismatches");
		$finish;
	end

	// offer one byte; optional random idle gap first, valid stays up afterward
	// so back-to-back requests never see valid drop and rise in one step
	task automatic send_byte(input logic [BYTE_W-1:0] b);
		bit taken;
		while ($urandom_range(99) < tx_idle_pct) begin
			rx_ch.valid <= 1'b0;
			rx_ch.rx_byte <= BYTE_W'($urandom_range(255));
			@(posedge clk);
		end
		rx_ch.valid <= 1'b1;
		rx_ch.rx_byte <= b;
		// sample the handshake mid-cycle, when nothing is moving
		do begin
			@(negedge clk);
			taken = rx_ch.ready;
			@(posedge clk);
		end while (!taken);
		sb.note_byte(b);
		bytes_sent++;
	endtask

	// preamble, code, length, payload, crc; keep limits how much of it is sent
	task automatic send_frame(input logic [BYTE_W-1:0] code, input int len,
		input bit corrupt, input int keep);
		logic [BYTE_W-1:0] fr [$];
		logic [BYTE_W-1:0] acc;
		fr = {PRE_FIRST, PRE_SECOND, code, BYTE_W'(len)};
		acc = crc8_d5_step('0, code);
		acc = crc8_d5_step(acc, BYTE_W'(len));
		for (int i = 0; i < len; i++) begin
			fr.push_back(BYTE_W'($urandom_range(255)));
			acc = crc8_d5_step(acc, fr[$]);
		end
		// a nonzero flip guarantees the crc no longer matches
		if (corrupt) begin
			acc ^= BYTE_W'($urandom_range(1, 255));
		end
		fr.push_back(acc);
		foreach (fr[i]) begin
			if (i < keep) begin
				send_byte(fr[i]);
			end
		end
	endtask

	// one random chunk of traffic: mostly well-formed frames, some noise
	task automatic send_random_chunk();
		int sel;
		int len;
		logic [BYTE_W-1:0] b;
		sel = $urandom_range(99);
		len = $urandom_range(9);
		// length extremes get extra weight
		if (len == 0) begin
			len = 0;
		end else if (len == 1) begin
			len = int'(MAX_LEN);
		end else begin
			len = $urandom_range(1, int'(MAX_LEN));
		end
		if (sel < 72) begin
			send_frame(BYTE_W'($urandom_range(255)), len, $urandom_range(99) < 15, 1000);
		end else if (sel < 80) begin
			// line noise, mostly ignored while hunting
			repeat ($urandom_range(1, 4)) begin
				send_byte(BYTE_W'($urandom_range(255)));
			end
		end else if (sel < 87) begin
			// first preamble byte followed by anything but the second
			b = BYTE_W'($urandom_range(255));
			if (b == PRE_SECOND) begin
				b = ~b;
			end
			send_byte(PRE_FIRST);
			send_byte(b);
		end else if (sel < 94) begin
			// length over the limit
			send_frame(BYTE_W'($urandom_range(255)), $urandom_range(int'(MAX_LEN) + 1, 255),
				1'b0, 4);
		end else begin
			// frame cut short; following traffic is parsed as the rest of the frame
			send_frame(BYTE_W'($urandom_range(255)), len, 1'b0, $urandom_range(3, len + 4));
		end
	endtask

	// result side: random ready, plus one long hold-off when asked
	initial begin : result_sink
		frc8_result_t got;
		bit fire;
		bit long_hold_done;
		int hold_left;
		hold_left = 0;
		long_hold_done = 1'b0;
		ev_ch.ready <= 1'b0;
		forever begin
			@(negedge clk);
			fire = ev_ch.valid && ev_ch.ready;
			got.kind = ev_ch.event_kind;
			got.data = ev_ch.frame_byte;
			got.idx = ev_ch.byte_index;
			got.last = ev_ch.last;
			@(posedge clk);
			if (fire) begin
				sb.check_result(got);
			end
			if (hold_left > 0) begin
				ev_ch.ready <= 1'b0;
				hold_left--;
			end else if (long_hold_due && !long_hold_done) begin
				// long enough for the output register to fill and rx to stall
				hold_left = 400;
				long_hold_done = 1'b1;
				ev_ch.ready <= 1'b0;
			end else begin
				ev_ch.ready <= ($urandom_range(99) >= rx_idle_pct);
			end
		end
	end

	initial begin : byte_source
		int target;
		int wait_cycles;
		arst_n <= 1'b0;
		rx_ch.valid <= 1'b0;
		rx_ch.rx_byte <= '0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: ignored bytes at both extremes
		send_byte(8'h00);
		send_byte(8'hFF);
		// repeated first preamble byte reports a bad preamble
		send_byte(PRE_FIRST);
		send_byte(PRE_FIRST);
		// zero-length frame, crc follows the length directly
		send_frame(8'h00, 0, 1'b0, 1000);
		// crc mismatch with odd code: echo dropped
		send_frame(8'hFF, 0, 1'b1, 1000);
		// crc mismatch with even code: crc error
		send_frame(8'hFE, 0, 1'b1, 1000);
		// length just over the limit and at the top of the byte range
		send_frame(8'h01, int'(MAX_LEN) + 1, 1'b0, 4);
		send_frame(8'h80, 255, 1'b0, 4);

		// random phases: receiver-heavy idling, sender-heavy idling, none plus one long hold-off
		for (int ph = 0; ph < 3; ph++) begin
			case (ph)
				0: begin
					tx_idle_pct = 38;
					rx_idle_pct = 50;
				end
				1: begin
					tx_idle_pct = 50;
					rx_idle_pct = 38;
				end
				default: begin
					tx_idle_pct = 0;
					rx_idle_pct = 0;
					long_hold_due = 1'b1;
				end
			endcase
			target = bytes_sent + 105;
			while (bytes_sent < target) begin
				send_random_chunk();
			end
		end
		rx_ch.valid <= 1'b0;

		// drain the remaining results, with a cap on the wait
		wait_cycles = 0;
		while (sb.pending() != 0 && wait_cycles < 100000) begin
			@(posedge clk);
			wait_cycles++;
		end
		if (sb.pending() == 0) begin
			repeat (60) @(posedge clk);
		end
		if (sb.pending() == 0 && sb.mismatches == 0) begin
			$display("end of test: clean");
		end else begin
			$display("end of test: mismatches");
		end
		$finish;
	end

endmodule

@@ sim.f @@
hdl/frc8_pkg.sv
hdl/frc8_if.sv
hdl/frc8_dp.sv
hdl/frc8_ctrl.sv
hdl/preamble_frame_receiver_crc8.sv
tb/sv/frc8_tb_pkg.sv
tb/sv/testbench.sv
